// File: hdl/vspp_pkg.sv
`default_nettype none

package vspp_pkg;

    // Fixed field widths of the request and result items.
    localparam int GRID_BITS      = 12;
    localparam int AXES           = 3;
    localparam int CENTER_BITS    = 32;
    localparam int STEP_BITS      = 24;
    localparam int COUNT_BITS     = 4;
    localparam int VALUE_BITS     = 32;
    localparam int RADIUS_BITS    = 32;
    localparam int SLOT_BITS      = 3;
    localparam int SQ_BITS        = 2 * CENTER_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Register stages inside the distance datapath.
    localparam int DIST_STAGES = 4;

    localparam int SHELL_ENTRIES_DEF = 8;
    localparam int RANK_ENTRIES_DEF  = 8;

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);

    typedef enum logic [1:0] {
        FUNC_LOAD_SHELL = 2'd0,
        FUNC_LOAD_RANK  = 2'd1,
        FUNC_PAINT      = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_CENTER_Z    = 3'd2,
        CFG_STEP_X      = 3'd3,
        CFG_STEP_Y      = 3'd4,
        CFG_STEP_Z      = 3'd5,
        CFG_SHELL_COUNT = 3'd6,
        CFG_RANK_COUNT  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        func_t                        func;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [GRID_BITS-1:0]  grid_x;
        logic signed [GRID_BITS-1:0]  grid_y;
        logic signed [GRID_BITS-1:0]  grid_z;
        logic [RADIUS_BITS-1:0]       shell_radius;
        logic [VALUE_BITS-1:0]        value_re;
        logic [VALUE_BITS-1:0]        value_im;
    } item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] new_re;
        logic [VALUE_BITS-1:0] new_im;
        logic                  replaced;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/voxel_shell_priority_painter_top.sv
`default_nettype none

// Voxel shell priority painter. Each request is a shell load, a rank load or a
// voxel paint, and each gives exactly one result in request order (loads and
// unused function codes return all zeros). Paints stream at one per cycle when
// the result is not stalled. Four stages build the saturating squared
// distance, one compares it against the radius of every counted shell and
// matches the current value against the rank list, one picks the tightest
// covering shell (lowest slot on ties), one muxes out its value, and the
// last ranks that value and forms the result. Load requests write the
// tables in the cycle they are accepted, so a load is held off while any paint
// is still in one of the seven stages before the result register. Results sit
// in an output register and upstream stages keep filling while it waits, so a
// stalled consumer only backs up the pipeline once every stage holds a request.
// The user must write configuration only while the block is idle; the block
// itself does not enforce it.
module voxel_shell_priority_painter_top #(
    parameter int SHELL_ENTRIES = vspp_pkg::SHELL_ENTRIES_DEF,
    parameter int RANK_ENTRIES  = vspp_pkg::RANK_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  vspp_pkg::item_t                       item,

    output logic                                  result_valid,
    input  logic                                  result_stall,
    output vspp_pkg::result_t                     result,

    input  logic                                  cfg_write,
    input  logic [vspp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [vspp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int NSTG  = vspp_pkg::DIST_STAGES + 4;
    localparam int RIDX  = (RANK_ENTRIES > 1) ? $clog2(RANK_ENTRIES) : 1;
    localparam int VW    = vspp_pkg::VALUE_BITS;
    localparam int SQW   = vspp_pkg::SQ_BITS;
    localparam int RADW  = vspp_pkg::RADIUS_BITS;
    localparam int S_RD  = vspp_pkg::DIST_STAGES;      // compare stage
    localparam int S_WIN = vspp_pkg::DIST_STAGES + 1;  // shell pick stage
    localparam int S_SEL = vspp_pkg::DIST_STAGES + 2;  // value mux stage
    localparam int S_OUT = vspp_pkg::DIST_STAGES + 3;  // result register

    // Side data that rides along the distance stages.
    typedef struct packed {
        logic          paint;
        logic [VW-1:0] re;
        logic [VW-1:0] im;
    } side_t;

    // Configuration registers.
    logic [vspp_pkg::CENTER_BITS-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [vspp_pkg::STEP_BITS-1:0]   step_x_reg, step_y_reg, step_z_reg;
    logic [vspp_pkg::COUNT_BITS-1:0]  shell_count_reg, rank_count_reg;

    // Shell and rank tables. They power up undefined and are written by loads.
    logic [SQW-1:0] rsq_reg      [SHELL_ENTRIES];
    logic [VW-1:0]  shell_re_reg [SHELL_ENTRIES];
    logic [VW-1:0]  shell_im_reg [SHELL_ENTRIES];
    logic [VW-1:0]  rank_re_reg  [RANK_ENTRIES];
    logic [VW-1:0]  rank_im_reg  [RANK_ENTRIES];
    logic [SQW-1:0] rsq_next;

    // Pipeline control.
    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   ready;
    logic [NSTG-1:0] en;
    logic [NSTG-2:0] paint_vec;
    logic            paint_inflight;
    logic            is_load;
    logic            accept;

    // Distance datapath hookup.
    logic [vspp_pkg::AXES-1:0][vspp_pkg::GRID_BITS-1:0]   grid_vec;
    logic [vspp_pkg::AXES-1:0][vspp_pkg::CENTER_BITS-1:0] center_vec;
    logic [vspp_pkg::AXES-1:0][vspp_pkg::STEP_BITS-1:0]   step_vec;
    logic [SQW-1:0]                                       dist_sq;

    // Stage payload.
    side_t                    side_reg [vspp_pkg::DIST_STAGES];
    side_t                    side_next;
    side_t                    rd_side_reg, win_side_reg, sel_side_reg;
    logic [SHELL_ENTRIES-1:0] shell_mask;
    logic [SHELL_ENTRIES-1:0] cand_reg, cand_next;
    logic [RANK_ENTRIES-1:0]  cmatch_reg, cmatch_next;
    logic [SHELL_ENTRIES-1:0] win_reg, win_next;
    logic                     cur_found_reg, cur_found_next, sel_cur_found_reg;
    logic [RIDX-1:0]          cur_idx_reg, cur_idx_next, sel_cur_idx_reg;
    logic                     shell_found_reg, shell_found_next;
    logic [VW-1:0]            shell_val_re_reg, shell_val_re_next;
    logic [VW-1:0]            shell_val_im_reg, shell_val_im_next;
    vspp_pkg::result_t        result_reg, result_next;
    logic                     out_paint_reg;

    // ------------------------------------------------------------------
    // Handshake. Each stage is free when empty or when the next one moves,
    // so bubbles collapse and a waiting result does not block the front.
    // ------------------------------------------------------------------
    always_comb
    begin
        ready[NSTG] = !result_stall;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < vspp_pkg::DIST_STAGES; k++)
        begin
            paint_vec[k] = side_reg[k].paint;
        end
        paint_vec[S_RD]  = rd_side_reg.paint;
        paint_vec[S_WIN] = win_side_reg.paint;
        paint_vec[S_SEL] = sel_side_reg.paint;
    end

    assign paint_inflight = |(valid_reg[NSTG-2:0] & paint_vec);
    assign is_load        = (item.func == vspp_pkg::FUNC_LOAD_SHELL) ||
                            (item.func == vspp_pkg::FUNC_LOAD_RANK);
    // A load must not overtake the table reads of paints ahead of it.
    assign item_stall     = !ready[0] || (is_load && paint_inflight);
    assign accept         = item_valid && !item_stall;

    always_comb
    begin
        en[0] = ready[0] && accept;
        for (int k = 1; k < NSTG; k++)
        begin
            en[k] = ready[k] && valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= accept;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
            step_x_reg      <= vspp_pkg::STEP_RESET;
            step_y_reg      <= vspp_pkg::STEP_RESET;
            step_z_reg      <= vspp_pkg::STEP_RESET;
            shell_count_reg <= '0;
            rank_count_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (vspp_pkg::cfg_reg_t'(cfg_index))
                vspp_pkg::CFG_CENTER_X:    center_x_reg    <= cfg_data;
                vspp_pkg::CFG_CENTER_Y:    center_y_reg    <= cfg_data;
                vspp_pkg::CFG_CENTER_Z:    center_z_reg    <= cfg_data;
                vspp_pkg::CFG_STEP_X:      step_x_reg      <= cfg_data[vspp_pkg::STEP_BITS-1:0];
                vspp_pkg::CFG_STEP_Y:      step_y_reg      <= cfg_data[vspp_pkg::STEP_BITS-1:0];
                vspp_pkg::CFG_STEP_Z:      step_z_reg      <= cfg_data[vspp_pkg::STEP_BITS-1:0];
                vspp_pkg::CFG_SHELL_COUNT: shell_count_reg <= cfg_data[vspp_pkg::COUNT_BITS-1:0];
                vspp_pkg::CFG_RANK_COUNT:  rank_count_reg  <= cfg_data[vspp_pkg::COUNT_BITS-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Table writes happen as a load request is accepted. A slot beyond the
    // table depth matches no entry, so that load changes nothing.
    // ------------------------------------------------------------------
    assign rsq_next = {{RADW{1'b0}}, item.shell_radius} * {{RADW{1'b0}}, item.shell_radius};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SHELL_ENTRIES; i++)
        begin
            if (accept && item.func == vspp_pkg::FUNC_LOAD_SHELL && int'(item.slot) == i)
            begin
                rsq_reg[i]      <= rsq_next;
                shell_re_reg[i] <= item.value_re;
                shell_im_reg[i] <= item.value_im;
            end
        end
        for (int j = 0; j < RANK_ENTRIES; j++)
        begin
            if (accept && item.func == vspp_pkg::FUNC_LOAD_RANK && int'(item.slot) == j)
            begin
                rank_re_reg[j] <= item.value_re;
                rank_im_reg[j] <= item.value_im;
            end
        end
    end

    // ------------------------------------------------------------------
    // Distance stages.
    // ------------------------------------------------------------------
    assign grid_vec   = {item.grid_z, item.grid_y, item.grid_x};
    assign center_vec = {center_z_reg, center_y_reg, center_x_reg};
    assign step_vec   = {step_z_reg, step_y_reg, step_x_reg};

    vspp_dist u_dist (
        .clk     (clk),
        .en      (en[vspp_pkg::DIST_STAGES-1:0]),
        .grid    (grid_vec),
        .center  (center_vec),
        .step    (step_vec),
        .dist_sq (dist_sq)
    );

    assign side_next = '{paint: (item.func == vspp_pkg::FUNC_PAINT),
                         re:    item.value_re,
                         im:    item.value_im};

    // ------------------------------------------------------------------
    // Compare, pick, select and rank stages.
    // ------------------------------------------------------------------
    always_comb
    begin
        // Compare stage: which shells cover the distance, and where the
        // current value appears in the rank list.
        for (int i = 0; i < SHELL_ENTRIES; i++)
        begin
            shell_mask[i] = (i < int'(shell_count_reg));
            cand_next[i]  = shell_mask[i] && (rsq_reg[i] >= dist_sq);
        end
        for (int j = 0; j < RANK_ENTRIES; j++)
        begin
            cmatch_next[j] = (j < int'(rank_count_reg)) &&
                             (rank_re_reg[j] == side_reg[vspp_pkg::DIST_STAGES-1].re) &&
                             (rank_im_reg[j] == side_reg[vspp_pkg::DIST_STAGES-1].im);
        end

        // Pick stage: a candidate wins unless a lower slot has a radius that is
        // no larger, or a higher slot has a strictly smaller one.
        for (int i = 0; i < SHELL_ENTRIES; i++)
        begin
            win_next[i] = cand_reg[i];
            for (int j = 0; j < SHELL_ENTRIES; j++)
            begin
                if (cand_reg[j] && j < i && rsq_reg[j] <= rsq_reg[i])
                begin
                    win_next[i] = 1'b0;
                end
                if (cand_reg[j] && j > i && rsq_reg[j] < rsq_reg[i])
                begin
                    win_next[i] = 1'b0;
                end
            end
        end
        // The rank of a value is its last match in the list.
        cur_found_next = |cmatch_reg;
        cur_idx_next   = '0;
        for (int j = 0; j < RANK_ENTRIES; j++)
        begin
            if (cmatch_reg[j])
            begin
                cur_idx_next = RIDX'(j);
            end
        end

        // Select stage: the winner is one-hot, so an AND-OR mux suffices.
        shell_found_next  = |win_reg;
        shell_val_re_next = '0;
        shell_val_im_next = '0;
        for (int i = 0; i < SHELL_ENTRIES; i++)
        begin
            shell_val_re_next = shell_val_re_next | ({VW{win_reg[i]}} & shell_re_reg[i]);
            shell_val_im_next = shell_val_im_next | ({VW{win_reg[i]}} & shell_im_reg[i]);
        end
    end

    // Result stage: rank the shell value and decide whether it overwrites.
    always_comb
    begin
        logic [RANK_ENTRIES-1:0] smatch;
        logic                    s_found;
        logic [RIDX-1:0]         s_idx;
        logic                    higher;
        s_idx = '0;
        for (int j = 0; j < RANK_ENTRIES; j++)
        begin
            smatch[j] = (j < int'(rank_count_reg)) &&
                        (rank_re_reg[j] == shell_val_re_reg) &&
                        (rank_im_reg[j] == shell_val_im_reg);
            if (smatch[j])
            begin
                s_idx = RIDX'(j);
            end
        end
        s_found = |smatch;
        // An absent value ranks below every listed one.
        higher  = shell_found_reg && s_found &&
                  (!sel_cur_found_reg || (s_idx > sel_cur_idx_reg));

        result_next = '0;
        if (sel_side_reg.paint)
        begin
            if (higher)
            begin
                result_next.new_re   = shell_val_re_reg;
                result_next.new_im   = shell_val_im_reg;
                result_next.replaced = 1'b1;
            end
            else
            begin
                result_next.new_re = sel_side_reg.re;
                result_next.new_im = sel_side_reg.im;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_next;
        end
        for (int k = 1; k < vspp_pkg::DIST_STAGES; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (en[S_RD])
        begin
            rd_side_reg <= side_reg[vspp_pkg::DIST_STAGES-1];
            cand_reg    <= cand_next;
            cmatch_reg  <= cmatch_next;
        end
        if (en[S_WIN])
        begin
            win_side_reg  <= rd_side_reg;
            win_reg       <= win_next;
            cur_found_reg <= cur_found_next;
            cur_idx_reg   <= cur_idx_next;
        end
        if (en[S_SEL])
        begin
            sel_side_reg      <= win_side_reg;
            shell_found_reg   <= shell_found_next;
            shell_val_re_reg  <= shell_val_re_next;
            shell_val_im_reg  <= shell_val_im_next;
            sel_cur_found_reg <= cur_found_reg;
            sel_cur_idx_reg   <= cur_idx_reg;
        end
        if (en[S_OUT])
        begin
            result_reg    <= result_next;
            out_paint_reg <= sel_side_reg.paint;
        end
    end

    assign result_valid = valid_reg[S_OUT];
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    ap_win_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_WIN] |-> $onehot0(win_reg))
        else $error("more than one shell picked for a paint request");

    ap_cand_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_RD] |-> ((cand_reg & ~shell_mask) == '0))
        else $error("shell candidate beyond the loaded shell count");

    ap_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !out_paint_reg) |-> (result == '0))
        else $error("non-paint request produced a nonzero result");

    ap_sel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[S_SEL] && !ready[S_OUT]) |=> valid_reg[S_SEL])
        else $error("request dropped from select stage while blocked");

endmodule

`default_nettype wire

// File: hdl/vspp_dist.sv
`default_nettype none

// Squared distance of a voxel from the ball center, four register stages:
// offset, magnitude, square, saturating sum.
module vspp_dist (
    input  logic                                                  clk,
    input  logic [vspp_pkg::DIST_STAGES-1:0]                      en,
    input  logic [vspp_pkg::AXES-1:0][vspp_pkg::GRID_BITS-1:0]    grid,
    input  logic [vspp_pkg::AXES-1:0][vspp_pkg::CENTER_BITS-1:0]  center,
    input  logic [vspp_pkg::AXES-1:0][vspp_pkg::STEP_BITS-1:0]    step,
    output logic [vspp_pkg::SQ_BITS-1:0]                          dist_sq
);

    localparam int DW   = vspp_pkg::GRID_BITS + vspp_pkg::STEP_BITS + 2;
    localparam int MAGW = vspp_pkg::CENTER_BITS;
    localparam int SQW  = vspp_pkg::SQ_BITS;

    logic [vspp_pkg::AXES-1:0][DW-1:0]   diff_reg, diff_next;
    logic [vspp_pkg::AXES-1:0][MAGW-1:0] mag_reg, mag_next;
    logic [vspp_pkg::AXES-1:0]           big_reg, big_next, big_sq_reg;
    logic [vspp_pkg::AXES-1:0][SQW-1:0]  sq_reg, sq_next;
    logic [SQW-1:0]                      dist_reg, dist_next;

    always_comb
    begin
        logic [DW-1:0]    abs_val;
        logic [SQW+1:0]   sum;
        abs_val = '0;
        sum     = '0;
        for (int a = 0; a < vspp_pkg::AXES; a++)
        begin
            // Signed offset: center minus grid index times grid step.
            diff_next[a] = DW'($signed(center[a]))
                         - DW'($signed(grid[a])) * DW'($signed({1'b0, step[a]}));

            abs_val     = diff_reg[a][DW-1] ? (~diff_reg[a] + DW'(1)) : diff_reg[a];
            big_next[a] = |abs_val[DW-1:MAGW];
            mag_next[a] = abs_val[MAGW-1:0];

            sq_next[a] = {{MAGW{1'b0}}, mag_reg[a]} * {{MAGW{1'b0}}, mag_reg[a]};

            sum = sum + (SQW+2)'(sq_reg[a]);
        end
        // A magnitude of 2^32 or more, or a carry out of the sum, saturates.
        dist_next = ((|big_sq_reg) || (|sum[SQW+1:SQW])) ? '1 : sum[SQW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            diff_reg <= diff_next;
        end
        if (en[1])
        begin
            mag_reg <= mag_next;
            big_reg <= big_next;
        end
        if (en[2])
        begin
            sq_reg     <= sq_next;
            big_sq_reg <= big_reg;
        end
        if (en[3])
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_sq = dist_reg;

endmodule

`default_nettype wire
